// File: rtl/lpda_pkg.sv
`timescale 1ns / 1ps

package lpda_pkg;

    localparam int NUM_CLASSES = 32;
    localparam int MASK_W      = 32;
    localparam int CLASS_W     = 5;
    localparam int HOLD_W      = 16;
    localparam int ELAPSED_W   = 17;
    localparam int MODE_W      = 3;
    localparam int OP_W        = 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // Watched bits beyond the class count never take part.
    localparam logic [MASK_W-1:0] CLASS_LIMIT = (NUM_CLASSES >= MASK_W) ? {MASK_W{1'b1}} :
        MASK_W'((64'(1) << NUM_CLASSES) - 64'(1));

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = ELAPSED_W'(1) << HOLD_W;

    localparam logic [OP_W-1:0] OP_DET  = 2'd0;
    localparam logic [OP_W-1:0] OP_EOF  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NOT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AND    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OR     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_XOR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALWAYS = 3'd4;

    localparam logic [1:0] REG_GATE_MODE    = 2'd0;
    localparam logic [1:0] REG_LABEL_MASK   = 2'd1;
    localparam logic [1:0] REG_HOLD_SECONDS = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] gate_mode;
        logic [MASK_W-1:0] label_mask;
        logic [HOLD_W-1:0] hold_seconds;
    } t_cfg;

endpackage

// File: rtl/lpda_apb_regs.sv
`timescale 1ns / 1ps

module lpda_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpda_pkg::ADDR_W-1:0] paddr,
    input  logic [lpda_pkg::DATA_W-1:0] pwdata,
    output logic [lpda_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lpda_pkg::t_cfg              o_cfg
);
    import lpda_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_mode    <= MODE_ALWAYS;
            r_cfg.label_mask   <= '0;
            r_cfg.hold_seconds <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GATE_MODE:    r_cfg.gate_mode    <= pwdata[MODE_W-1:0];
                REG_LABEL_MASK:   r_cfg.label_mask   <= pwdata[MASK_W-1:0];
                REG_HOLD_SECONDS: r_cfg.hold_seconds <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GATE_MODE:    prdata = DATA_W'(r_cfg.gate_mode);
            REG_LABEL_MASK:   prdata = DATA_W'(r_cfg.label_mask);
            REG_HOLD_SECONDS: prdata = DATA_W'(r_cfg.hold_seconds);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/lpda_core.sv
`timescale 1ns / 1ps

module lpda_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lpda_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lpda_pkg::OP_W-1:0]      i_op,
    input  logic [lpda_pkg::CLASS_W-1:0]   i_class_id,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_report,
    output logic [lpda_pkg::ELAPSED_W-1:0] o_elapsed_now
);
    import lpda_pkg::*;

    // input stage
    logic                 r_in_valid;
    logic [OP_W-1:0]      r_op;
    logic [CLASS_W-1:0]   r_cls;

    // frame and dwell state
    logic [MASK_W-1:0]    r_seen, n_seen;
    logic                 r_foreign, n_foreign;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;

    // result register
    logic                 r_out_valid;
    logic                 r_report, n_report;
    logic [ELAPSED_W-1:0] r_elapsed_now;

    logic                 out_free;
    logic                 advance;
    logic                 produce;
    logic [MASK_W-1:0]    watched;
    logic [MASK_W-1:0]    hit;
    logic [MASK_W-1:0]    cls_bit;
    logic                 cls_ok;
    logic                 restart;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || advance;
    assign produce  = advance && (r_op == OP_EOF);

    assign watched  = i_cfg.label_mask & CLASS_LIMIT;
    assign hit      = r_seen & watched;
    assign cls_bit  = MASK_W'(1) << r_cls;
    assign cls_ok   = 32'(r_cls) < NUM_CLASSES;

    always_comb begin
        unique case (i_cfg.gate_mode)
            MODE_NOT: restart = hit != '0;
            MODE_AND: restart = hit != watched;
            MODE_OR:  restart = r_foreign;
            MODE_XOR: restart = (hit != '0) && ((hit & (hit - MASK_W'(1))) == '0);
            default:  restart = 1'b1;
        endcase
    end

    always_comb begin
        n_seen    = r_seen;
        n_foreign = r_foreign;
        n_elapsed = r_elapsed;
        // a restart zeroes the counter first, so only a held count can report
        n_report  = !restart && (r_elapsed > ELAPSED_W'(i_cfg.hold_seconds));
        unique case (r_op)
            OP_DET: begin
                if (cls_ok) begin
                    if ((i_cfg.label_mask & cls_bit) != '0) begin
                        n_seen = r_seen | cls_bit;
                    end else begin
                        n_foreign = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_elapsed < ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + ELAPSED_W'(1);
                end
            end
            OP_EOF: begin
                n_seen    = '0;
                n_foreign = 1'b0;
                if (restart || n_report) begin
                    n_elapsed = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_seen      <= '0;
            r_foreign   <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_seen    <= n_seen;
                r_foreign <= n_foreign;
                r_elapsed <= n_elapsed;
            end
            // hold the result until the downstream transfer
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op  <= i_op;
            r_cls <= i_class_id;
        end
        if (produce) begin
            r_report      <= n_report;
            r_elapsed_now <= r_elapsed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_report      = r_report;
    assign o_elapsed_now = r_elapsed_now;

endmodule

// File: rtl/label_presence_dwell_alarm.sv
`timescale 1ns / 1ps

// Label presence dwell alarm. Takes one item (detection, end of frame or
// one-second tick) per clock unless a waiting result holds the input; each
// transfer is registered, then applied to the frame mask and elapsed counter
// once the output register is free. An end of frame loads its result into
// the output register as that update is applied, which raises o_valid. The
// rate is set by the state update between the input and result registers. A
// result that waits in the output register holds every item in the input
// register, whatever its kind, so the input stops after at most one more
// transfer until the result is taken. Configure only while idle.

module label_presence_dwell_alarm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpda_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpda_pkg::DATA_W-1:0]    pwdata,
    output logic [lpda_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lpda_pkg::OP_W-1:0]      i_op,
    input  logic [lpda_pkg::CLASS_W-1:0]   i_class_id,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_report,
    output logic [lpda_pkg::ELAPSED_W-1:0] o_elapsed_now
);
    import lpda_pkg::*;

    t_cfg cfg;

    lpda_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lpda_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_class_id    (i_class_id),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_report      (o_report),
        .o_elapsed_now (o_elapsed_now)
    );

endmodule
